>>> sv/tedet_pkg.sv
// ============================================================================
// tedet_pkg
// Shared codes and byte-class helpers for the text encoding detector.
// ============================================================================
package tedet_pkg;

    // Verdict codes on m_encoding
    localparam logic [1:0] ENC_NONE  = 2'd0;
    localparam logic [1:0] ENC_UTF8  = 2'd1;
    localparam logic [1:0] ENC_SJIS  = 2'd2;
    localparam logic [1:0] ENC_EUCKR = 2'd3;

    typedef logic [7:0] byte_t;

    function automatic logic in_range(input byte_t v, input byte_t lo, input byte_t hi);
        return (v >= lo) && (v <= hi);
    endfunction

    // Shift-JIS lead of a double-byte character (0x81-0x9E or 0xE0-0xEE)
    function automatic logic sjis_lead(input byte_t b);
        return in_range(b, 8'h81, 8'h9E) || in_range(b, 8'hE0, 8'hEE);
    endfunction

    // Shift-JIS trail byte
    function automatic logic sjis_trail(input byte_t b);
        return in_range(b, 8'h40, 8'h7E) || in_range(b, 8'h80, 8'hFC);
    endfunction

    // EUC-KR (KS X 1001) pair or CP949 extended pair
    function automatic logic euckr_pair(input byte_t lead, input byte_t b);
        logic ks;
        logic ext;
        ks  = in_range(lead, 8'hA1, 8'hFE) && in_range(b, 8'hA1, 8'hFE);
        ext = in_range(lead, 8'h81, 8'hC5) &&
              (in_range(b, 8'h41, 8'h5A) || in_range(b, 8'h61, 8'h7A) ||
               in_range(b, 8'h81, 8'hFE));
        return ks || ext;
    endfunction

endpackage

>>> sv/text_encoding_detector.sv
// ============================================================================
// text_encoding_detector
// Byte-wide charset checker: UTF-8, Shift-JIS and EUC-KR/CP949 side by side.
// ============================================================================
// A verdict appears on m_valid in the cycle after its final word is
// accepted. Throughput: one word per cycle; the only limit is the single
// result register, which still takes a new word while m_ready is high.
// Reset (aresetn low, synchronous): all validators pass, nothing pending,
// no verdict held.
module text_encoding_detector (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tedet_pkg::byte_t     s_data_byte,
    input  logic                 s_end_of_string,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_encoding
);
    import tedet_pkg::*;

    // Validator state
    logic       utf8_valid_reg,   utf8_valid_next;
    logic [1:0] utf8_owed_reg,    utf8_owed_next;
    logic       sjis_valid_reg,   sjis_valid_next;
    logic       sjis_due_reg,     sjis_due_next;
    logic       euckr_valid_reg,  euckr_valid_next;
    logic       euckr_due_reg,    euckr_due_next;
    byte_t      euckr_lead_reg,   euckr_lead_next;
    logic       ended_reg,        ended_next;

    // Result register
    logic       m_valid_reg,      m_valid_next;
    logic [1:0] m_encoding_reg,   m_encoding_next;

    logic       accept;

    // Take a new word whenever the result slot is free or being drained.
    assign s_ready    = !m_valid_reg || m_ready;
    assign accept     = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_encoding = m_encoding_reg;

    always_comb begin
        utf8_valid_next  = utf8_valid_reg;
        utf8_owed_next   = utf8_owed_reg;
        sjis_valid_next  = sjis_valid_reg;
        sjis_due_next    = sjis_due_reg;
        euckr_valid_next = euckr_valid_reg;
        euckr_due_next   = euckr_due_reg;
        euckr_lead_next  = euckr_lead_reg;
        ended_next       = ended_reg;
        m_encoding_next  = m_encoding_reg;
        m_valid_next     = m_valid_reg && !m_ready;

        if (accept) begin
            if (!ended_reg) begin
                if (s_data_byte == 8'h00) begin
                    // Terminator: fail any validator with a sequence open.
                    ended_next = 1'b1;
                    if (utf8_owed_reg != 2'd0) utf8_valid_next = 1'b0;
                    if (sjis_due_reg)          sjis_valid_next = 1'b0;
                    if (euckr_due_reg)         euckr_valid_next = 1'b0;
                    utf8_owed_next = 2'd0;
                    sjis_due_next  = 1'b0;
                    euckr_due_next = 1'b0;
                end else begin
                    // UTF-8: lead sets the continuation count, each
                    // continuation must be 10xxxxxx.
                    if (utf8_valid_reg) begin
                        if (utf8_owed_reg != 2'd0) begin
                            if (s_data_byte[7:6] != 2'b10) begin
                                utf8_valid_next = 1'b0;
                                utf8_owed_next  = 2'd0;
                            end else begin
                                utf8_owed_next = utf8_owed_reg - 2'd1;
                            end
                        end else if (!s_data_byte[7]) begin
                            utf8_owed_next = 2'd0;
                        end else if ((s_data_byte & 8'hE0) == 8'hC0) begin
                            utf8_owed_next = 2'd1;
                        end else if ((s_data_byte & 8'hF0) == 8'hE0) begin
                            utf8_owed_next = 2'd2;
                        end else if ((s_data_byte & 8'hF8) == 8'hF0) begin
                            utf8_owed_next = 2'd3;
                        end else begin
                            utf8_valid_next = 1'b0;
                        end
                    end
                    // Shift-JIS: lead then one trail.
                    if (sjis_valid_reg) begin
                        if (sjis_due_reg) begin
                            sjis_due_next = 1'b0;
                            if (!sjis_trail(s_data_byte)) sjis_valid_next = 1'b0;
                        end else if (!s_data_byte[7]) begin
                            sjis_due_next = 1'b0;
                        end else if (sjis_lead(s_data_byte)) begin
                            sjis_due_next = 1'b1;
                        end else begin
                            sjis_valid_next = 1'b0;
                        end
                    end
                    // EUC-KR/CP949: hold the lead, check the pair on the trail.
                    if (euckr_valid_reg) begin
                        if (euckr_due_reg) begin
                            euckr_due_next = 1'b0;
                            if (!euckr_pair(euckr_lead_reg, s_data_byte)) begin
                                euckr_valid_next = 1'b0;
                            end
                        end else if (!s_data_byte[7]) begin
                            euckr_due_next = 1'b0;
                        end else if (in_range(s_data_byte, 8'h81, 8'hFE)) begin
                            euckr_due_next  = 1'b1;
                            euckr_lead_next = s_data_byte;
                        end else begin
                            euckr_valid_next = 1'b0;
                        end
                    end
                end
            end

            if (s_end_of_string) begin
                // Close open sequences, pick by priority, drop back to reset.
                priority if (utf8_valid_next && utf8_owed_next == 2'd0) begin
                    m_encoding_next = ENC_UTF8;
                end else if (sjis_valid_next && !sjis_due_next) begin
                    m_encoding_next = ENC_SJIS;
                end else if (euckr_valid_next && !euckr_due_next) begin
                    m_encoding_next = ENC_EUCKR;
                end else begin
                    m_encoding_next = ENC_NONE;
                end
                m_valid_next     = 1'b1;
                utf8_valid_next  = 1'b1;
                utf8_owed_next   = 2'd0;
                sjis_valid_next  = 1'b1;
                sjis_due_next    = 1'b0;
                euckr_valid_next = 1'b1;
                euckr_due_next   = 1'b0;
                euckr_lead_next  = 8'h00;
                ended_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            utf8_valid_reg  <= 1'b1;
            utf8_owed_reg   <= 2'd0;
            sjis_valid_reg  <= 1'b1;
            sjis_due_reg    <= 1'b0;
            euckr_valid_reg <= 1'b1;
            euckr_due_reg   <= 1'b0;
            ended_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            utf8_valid_reg  <= utf8_valid_next;
            utf8_owed_reg   <= utf8_owed_next;
            sjis_valid_reg  <= sjis_valid_next;
            sjis_due_reg    <= sjis_due_next;
            euckr_valid_reg <= euckr_valid_next;
            euckr_due_reg   <= euckr_due_next;
            ended_reg       <= ended_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        euckr_lead_reg <= euckr_lead_next;
        m_encoding_reg <= m_encoding_next;
    end

endmodule
